>>> rtl/tlbplru_pkg.sv
// shared types and constants for the translation unit
package tlbplru_pkg;

  localparam int TLB_ENTRIES     = 16;
  localparam int PAGE_COUNT      = 256;
  localparam int FRAME_COUNT_MAX = 256;
  localparam int TLB_IDX_W       = $clog2(TLB_ENTRIES);
  localparam int PAGE_W          = 8;
  localparam int FRAME_W         = 8;
  localparam int OFFSET_W        = 8;
  localparam int ADDR_W          = 16;
  localparam int NFRAMES_W       = 9;
  localparam int STAMP_W         = 32;
  localparam int PIDX_W          = $clog2(PAGE_COUNT);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_SCAN,
    ST_SCAN_LAST,
    ST_COMMIT,
    ST_OUT
  } state_t;

endpackage

>>> rtl/tlb_page_table_lru_translate.sv
// translation unit: fifo tlb in front of a page table with lru replacement
// path: an input beat passes the lookup and commit states to the output register,
//   plus a scan of the page table, one entry a cycle, when a fault needs a victim
// flow: one beat in flight; the next beat is taken the cycle after the output
//   register loads, even while that result waits
// reset: synchronous active low; valid bits and counters cleared, limit back to 256
module tlb_page_table_lru_translate (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_logical_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_physical_address,
  output logic [7:0]  out_frame_number,
  output logic        out_tlb_hit,
  output logic        out_page_fault,
  output logic        out_evicted,
  output logic [7:0]  out_evicted_page,
  input  logic        cfg_we,
  input  logic [8:0]  cfg_wdata
);
  import tlbplru_pkg::*;

  // tlb held in flip-flops: small and searched in parallel
  logic [PAGE_W-1:0]  tlb_page_r  [TLB_ENTRIES];
  logic [FRAME_W-1:0] tlb_frame_r [TLB_ENTRIES];
  logic [TLB_ENTRIES-1:0] tlb_valid_r;
  logic [TLB_IDX_W-1:0]   tlb_fill_r;

  // page table: frame and last-use stamp in one memory, valid bits in flops
  logic [FRAME_W+STAMP_W-1:0] pt_mem [PAGE_COUNT];
  logic [PAGE_COUNT-1:0]      page_valid_r;
  logic [FRAME_W+STAMP_W-1:0] pt_rdata_r;
  logic                       pt_we;
  logic [PIDX_W-1:0]          pt_waddr, pt_raddr;
  logic [FRAME_W+STAMP_W-1:0] pt_wdata;

  logic [STAMP_W-1:0]   stamp_r;
  logic [NFRAMES_W-1:0] frames_used_r, num_frames_r;

  state_t state_r, state_nxt;

  logic [PAGE_W-1:0]   page_r;
  logic [OFFSET_W-1:0] offset_r;
  logic                hit_r;
  logic [FRAME_W-1:0]  hit_frame_r;
  logic [FRAME_W-1:0]  frame_r;
  logic                fault_r, ev_r;
  logic [PAGE_W-1:0]   ev_page_r;

  // lru scan state
  logic [PIDX_W:0]     scan_cnt_r;
  logic [PIDX_W-1:0]   scan_idx_r;  // address of the entry now in pt_rdata_r
  logic                found_r;
  logic [PIDX_W-1:0]   best_r;
  logic [STAMP_W-1:0]  best_age_r;
  logic [FRAME_W-1:0]  best_frame_r;

  logic                out_valid_r;
  logic [15:0]         out_pa_r;
  logic [7:0]          out_fn_r, out_ep_r;
  logic                out_hit_r, out_pf_r, out_ev_r;

  // frame limit with out of range values clamped
  logic [NFRAMES_W-1:0] limit;
  always_comb begin
    limit = num_frames_r;
    if (num_frames_r > NFRAMES_W'(FRAME_COUNT_MAX)) limit = NFRAMES_W'(FRAME_COUNT_MAX);
    if (num_frames_r == '0) limit = NFRAMES_W'(1);
  end

  // parallel tlb compare, highest index wins
  logic               tlb_match;
  logic [FRAME_W-1:0] tlb_match_frame;
  always_comb begin
    tlb_match = 1'b0;
    tlb_match_frame = '0;
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      if (tlb_valid_r[i] && tlb_page_r[i] == in_logical_address[15:8]) begin
        tlb_match = 1'b1;
        tlb_match_frame = tlb_frame_r[i];
      end
    end
  end

  logic in_acc, out_acc;
  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid_r && !out_stall;
  assign in_stall = (state_r != ST_IDLE);

  logic [STAMP_W-1:0] scan_age;
  assign scan_age = stamp_r - pt_rdata_r[STAMP_W-1:0];
  logic scan_take;
  assign scan_take = page_valid_r[scan_idx_r] && (!found_r || scan_age > best_age_r);

  // frame the beat ends up with: the victim's frame when one was found
  logic               commit_ev;
  logic [FRAME_W-1:0] commit_frame;
  assign commit_ev    = fault_r && found_r;
  assign commit_frame = commit_ev ? best_frame_r : frame_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_acc) state_nxt = ST_LOOKUP;
      ST_LOOKUP: begin
        if (!hit_r && !page_valid_r[page_r] && frames_used_r >= limit)
          state_nxt = ST_SCAN;
        else
          state_nxt = ST_COMMIT;
      end
      ST_SCAN:      if (scan_cnt_r == (PIDX_W+1)'(PAGE_COUNT)) state_nxt = ST_SCAN_LAST;
      ST_SCAN_LAST: state_nxt = ST_COMMIT;
      ST_COMMIT:    state_nxt = ST_OUT;
      ST_OUT:       if (!out_valid_r || out_acc) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // memory port control
  always_comb begin
    pt_raddr = page_r;
    pt_we    = 1'b0;
    pt_waddr = page_r;
    pt_wdata = {commit_frame, stamp_r};
    unique case (state_r)
      ST_IDLE:   pt_raddr = in_logical_address[15:8];
      ST_SCAN:   pt_raddr = scan_cnt_r[PIDX_W-1:0];
      ST_COMMIT: pt_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pt_we) pt_mem[pt_waddr] <= pt_wdata;
    pt_rdata_r <= pt_mem[pt_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      tlb_valid_r   <= '0;
      tlb_fill_r    <= '0;
      page_valid_r  <= '0;
      stamp_r       <= '0;
      frames_used_r <= '0;
      num_frames_r  <= NFRAMES_W'(FRAME_COUNT_MAX);
      out_valid_r   <= 1'b0;
      found_r       <= 1'b0;
      scan_cnt_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) num_frames_r <= cfg_wdata;
      if (out_acc) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            page_r      <= in_logical_address[15:8];
            offset_r    <= in_logical_address[7:0];
            hit_r       <= tlb_match;
            hit_frame_r <= tlb_match_frame;
          end
        end
        ST_LOOKUP: begin
          fault_r    <= 1'b0;
          ev_r       <= 1'b0;
          ev_page_r  <= '0;
          found_r    <= 1'b0;
          best_age_r <= '0;
          scan_cnt_r <= '0;
          if (hit_r) begin
            frame_r <= hit_frame_r;
          end else if (page_valid_r[page_r]) begin
            frame_r <= pt_rdata_r[FRAME_W+STAMP_W-1:STAMP_W];
          end else begin
            fault_r <= 1'b1;
            if (frames_used_r < limit) begin
              frame_r       <= frames_used_r[FRAME_W-1:0];
              frames_used_r <= frames_used_r + 1'b1;
            end else begin
              frame_r <= '0;  // replaced by the victim's frame if one is found
            end
          end
        end
        ST_SCAN, ST_SCAN_LAST: begin
          // entry scan_idx_r arrived this cycle; the first scan cycle has none yet
          if (scan_cnt_r != '0 && scan_take) begin
            found_r      <= 1'b1;
            best_r       <= scan_idx_r;
            best_age_r   <= scan_age;
            best_frame_r <= pt_rdata_r[FRAME_W+STAMP_W-1:STAMP_W];
          end
          scan_idx_r <= scan_cnt_r[PIDX_W-1:0];
          if (state_r == ST_SCAN) scan_cnt_r <= scan_cnt_r + 1'b1;
        end
        ST_COMMIT: begin
          if (commit_ev) begin
            ev_r      <= 1'b1;
            ev_page_r <= best_r;
            frame_r   <= best_frame_r;
            page_valid_r[best_r] <= 1'b0;
          end
          if (fault_r) page_valid_r[page_r] <= 1'b1;
          if (!hit_r) begin
            for (int i = 0; i < TLB_ENTRIES; i++)
              if (commit_ev && tlb_valid_r[i] && tlb_page_r[i] == best_r)
                tlb_valid_r[i] <= 1'b0;
            tlb_page_r[tlb_fill_r]  <= page_r;
            tlb_frame_r[tlb_fill_r] <= commit_frame;
            tlb_valid_r[tlb_fill_r] <= 1'b1;
            tlb_fill_r <= tlb_fill_r + 1'b1;
          end
          stamp_r <= stamp_r + 1'b1;
        end
        ST_OUT: begin
          if (!out_valid_r || out_acc) begin
            out_valid_r <= 1'b1;
            out_pa_r    <= {frame_r, offset_r};
            out_fn_r    <= frame_r;
            out_hit_r   <= hit_r;
            out_pf_r    <= fault_r;
            out_ev_r    <= ev_r;
            out_ep_r    <= ev_page_r;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid            = out_valid_r;
  assign out_physical_address = out_pa_r;
  assign out_frame_number     = out_fn_r;
  assign out_tlb_hit          = out_hit_r;
  assign out_page_fault       = out_pf_r;
  assign out_evicted          = out_ev_r;
  assign out_evicted_page     = out_ep_r;

  // an evicting beat is always reported as a page fault; it needed a full scan first
  a_ev_fault: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && out_evicted |-> out_page_fault) else $error("eviction without fault");
  a_hit_nofault: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && out_tlb_hit |-> !out_page_fault) else $error("hit with fault");
  a_frames: assert property (@(posedge clk) disable iff (!rst_n)
    frames_used_r <= NFRAMES_W'(FRAME_COUNT_MAX)) else $error("frame count overflow");
endmodule
